// ----- rtl/swr_pkg.sv -----
// Shared types, constants and helper functions for the sliding-window receiver.
// Used by swr_rem_unit and sliding_window_receiver; depends on nothing else.
package swr_pkg;

   localparam int WINDOW_MAX  = 16;
   localparam int MAX_PAYLOAD = 500;
   localparam int IDX_W       = $clog2(WINDOW_MAX);
   localparam int WIN_W       = 5;
   localparam int SEQ_W       = 32;
   localparam int HLEN_W      = 16;
   localparam int LEN_W       = 9;
   localparam int KIND_W      = 3;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 5'd8;
   localparam logic [HLEN_W-1:0] HDR_ONLY_LEN = 16'd8;
   localparam logic [HLEN_W-1:0] HDR_EOF_LEN  = 16'd12;
   localparam logic [HLEN_W-1:0] MAX_FRAME    = HDR_EOF_LEN + HLEN_W'(MAX_PAYLOAD);

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 112;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMAINDER,
      ST_CLASSIFY,
      ST_DELIVER,
      ST_ACK
   } state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_MALFORMED = 3'd0,
      KIND_OUTSIDE   = 3'd1,
      KIND_DUPLICATE = 3'd2,
      KIND_ACK_ONLY  = 3'd3,
      KIND_STORED    = 3'd4,
      KIND_DELIVER   = 3'd5,
      KIND_SEND_ACK  = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  slot_seq;
      logic [LEN_W-1:0]  payload_length;
      logic [SEQ_W-1:0]  ack_out;
      logic [SEQ_W-1:0]  send_base;
      logic              eof_seen;
      logic              all_delivered;
      logic              last;
   } result_type;

   // Window sizes of zero act as one, sizes beyond the slot count are capped.
   function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = WIN_W'(1);
      end else if (w > WIN_W'(WINDOW_MAX)) begin
         r = WIN_W'(WINDOW_MAX);
      end
      return r;
   endfunction

   function automatic logic [RSP_TDATA_W-1:0] pack_rsp(input result_type r);
      logic [RSP_TDATA_W-1:0] d;
      d = '0;
      d[31:0]   = r.slot_seq;
      d[40:32]  = r.payload_length;
      d[72:41]  = r.ack_out;
      d[104:73] = r.send_base;
      d[105]    = r.eof_seen;
      d[106]    = r.all_delivered;
      return d;
   endfunction

endpackage

// ----- rtl/swr_rem_unit.sv -----
// Bit-serial remainder unit: a 32-bit dividend modulo a small divisor.
// Depends on swr_pkg; one dividend bit is consumed per cycle.
module swr_rem_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [swr_pkg::SEQ_W-1:0]   dividend,
   input  logic [swr_pkg::WIN_W-1:0]   divisor,
   output logic                        done,
   output logic [swr_pkg::WIN_W-1:0]   remainder
);
   import swr_pkg::*;

   localparam int CNT_W = $clog2(SEQ_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SEQ_W-1:0]    dividend_ff, dividend_in;
   logic [WIN_W-1:0]    divisor_ff, divisor_in;
   logic [WIN_W-1:0]    rem_ff, rem_in;
   logic [WIN_W:0]      trial;

   assign trial = {rem_ff, dividend_ff[SEQ_W-1]};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[SEQ_W-2:0], 1'b0};
         // The partial remainder stays below the divisor, so it fits the divisor width.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = WIN_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[WIN_W-1:0];
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(SEQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/sliding_window_receiver.sv -----
// Selective-repeat receive window: classifies one packet header per beat, stores
// in-window slots and releases in-order slots followed by an acknowledgement.
// Depends on swr_pkg and swr_rem_unit.
//
// An input beat is taken in the idle state and classified in the classify
// state, which also produces the first result; a packet that completes the
// in-order run then releases one delivered slot per cycle while the result
// side does not stall, and then one acknowledgement. Slot lengths live in a
// 16-entry memory with a registered read; the lookahead read of the next slot
// overlaps the current delivery, and a slot stored and delivered in the same
// packet is forwarded past the memory. A write to the window register starts a
// remainder computation, one dividend bit per cycle, that re-aligns the slot
// index of the next expected sequence number; no input beat is accepted until
// that computation is done. The valid marks are flip-flops, so reset needs no
// clearing pass.
module sliding_window_receiver (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata, lowest bit first: seq_number[31:0], ack_number[63:32],
   // header_length[79:64], received_bytes[95:80]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [swr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: checksum_ok
   input  logic                             req_tuser,
   // rsp_tdata, lowest bit first: slot_seq[31:0], payload_length[40:32],
   // ack_out[72:41], send_base[104:73], eof_seen[105], all_delivered[106], zeros
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [swr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: kind
   output logic [swr_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [swr_pkg::WIN_W-1:0]        csr_data
);
   import swr_pkg::*;

   state_type                 state_ff, state_in;
   logic [WIN_W-1:0]          window_ff, window_in;
   logic [SEQ_W-1:0]          expected_ff, expected_in;
   logic [IDX_W-1:0]          exp_idx_ff, exp_idx_in;
   logic [SEQ_W-1:0]          base_ff, base_in;
   logic                      eof_ff, eof_in;
   logic                      done_ff, done_in;
   logic [WINDOW_MAX-1:0]     valid_ff, valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;

   // Latched request beat.
   logic [SEQ_W-1:0]          seq_ff, ack_ff;
   logic [HLEN_W-1:0]         hlen_ff, nbytes_ff;
   logic                      ck_ff;

   // Slot length memory and its read port.
   logic [LEN_W-1:0]          len_mem [WINDOW_MAX];
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic                      byp_en;
   logic [LEN_W-1:0]          rd_len_ff;

   logic                      rem_start, rem_done;
   logic [WIN_W-1:0]          rem_value;

   logic                      req_acc, csr_acc, out_free;
   logic [WIN_W-1:0]          win;
   logic                      malformed;
   logic [SEQ_W:0]            seq_offset;
   logic                      in_window;
   logic [WIN_W-1:0]          idx_sum;
   logic [IDX_W-1:0]          slot_idx;
   logic [LEN_W-1:0]          pay_len;
   logic [SEQ_W-1:0]          base_upd;
   logic [WIN_W-1:0]          idx_inc;
   logic [IDX_W-1:0]          next_idx;

   swr_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (expected_ff),
      .divisor   (eff_window(window_in)),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_acc    = csr_valid && csr_ready;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign win = eff_window(window_ff);

   assign malformed = (nbytes_ff < HDR_ONLY_LEN) || (hlen_ff != nbytes_ff) ||
                      ((nbytes_ff > HDR_ONLY_LEN) && (nbytes_ff < HDR_EOF_LEN)) ||
                      (nbytes_ff > MAX_FRAME) || !ck_ff;

   // A borrow means the sequence lies below the window.
   assign seq_offset = {1'b0, seq_ff} - {1'b0, expected_ff};
   assign in_window  = !seq_offset[SEQ_W] && (seq_offset[SEQ_W-1:0] < SEQ_W'(win));

   // Inside the window the offset is below the window size, so one
   // conditional subtract brings the index back into range.
   assign idx_sum  = WIN_W'(exp_idx_ff) + WIN_W'(seq_offset[IDX_W-1:0]);
   assign slot_idx = (idx_sum >= win) ? IDX_W'(idx_sum - win) : idx_sum[IDX_W-1:0];

   assign pay_len  = LEN_W'(nbytes_ff - HDR_EOF_LEN);
   assign base_upd = (base_ff < ack_ff) ? ack_ff : base_ff;

   // The expected sequence wraps to zero after the top value, and so does its index.
   assign idx_inc  = WIN_W'(exp_idx_ff) + WIN_W'(1);
   assign next_idx = (expected_ff == '1 || idx_inc == win) ? '0 : idx_inc[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      expected_in  = expected_ff;
      exp_idx_in   = exp_idx_ff;
      base_in      = base_ff;
      eof_in       = eof_ff;
      done_in      = done_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_idx;
      rd_en        = 1'b0;
      rd_addr      = next_idx;
      byp_en       = 1'b0;
      rem_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               window_in = csr_data;
               valid_in  = '0;
               rem_start = 1'b1;
               state_in  = ST_REMAINDER;
            end else if (req_acc) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_REMAINDER: begin
            if (rem_done) begin
               exp_idx_in = rem_value[IDX_W-1:0];
               state_in   = ST_IDLE;
            end
         end
         ST_CLASSIFY: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.slot_seq       = '0;
               rsp_in.payload_length = '0;
               rsp_in.ack_out        = expected_ff;
               rsp_in.send_base      = base_upd;
               rsp_in.eof_seen       = eof_ff;
               rsp_in.all_delivered  = done_ff;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
               priority if (malformed) begin
                  rsp_in.kind      = KIND_MALFORMED;
                  rsp_in.send_base = base_ff;
               end else if (nbytes_ff == HDR_ONLY_LEN) begin
                  base_in     = base_upd;
                  rsp_in.kind = KIND_ACK_ONLY;
               end else if (!in_window) begin
                  base_in     = base_upd;
                  rsp_in.kind = KIND_OUTSIDE;
               end else if (valid_ff[slot_idx]) begin
                  base_in     = base_upd;
                  rsp_in.kind = KIND_DUPLICATE;
               end else begin
                  base_in               = base_upd;
                  eof_in                = eof_ff || (nbytes_ff == HDR_EOF_LEN);
                  mem_we                = 1'b1;
                  rsp_in.kind           = KIND_STORED;
                  rsp_in.slot_seq       = seq_ff;
                  rsp_in.payload_length = pay_len;
                  rsp_in.eof_seen       = eof_in;
                  if (seq_offset[SEQ_W-1:0] == '0) begin
                     // In order: the slot goes straight out, so its length is
                     // forwarded and its valid mark is never set.
                     byp_en      = 1'b1;
                     rsp_in.last = 1'b0;
                     state_in    = ST_DELIVER;
                  end else begin
                     valid_in[slot_idx] = 1'b1;
                  end
               end
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_DELIVER;
               rsp_in.slot_seq       = expected_ff;
               rsp_in.payload_length = rd_len_ff;
               rsp_in.ack_out        = expected_ff + SEQ_W'(1);
               rsp_in.send_base      = base_ff;
               rsp_in.eof_seen       = eof_ff;
               rsp_in.all_delivered  = done_ff;
               rsp_in.last           = 1'b0;
               expected_in           = expected_ff + SEQ_W'(1);
               exp_idx_in            = next_idx;
               // Look ahead at the next slot while this one is handed out.
               if (valid_ff[next_idx]) begin
                  rd_en              = 1'b1;
                  valid_in[next_idx] = 1'b0;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               done_in               = done_ff || (eof_ff && (valid_ff == '0));
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_SEND_ACK;
               rsp_in.slot_seq       = '0;
               rsp_in.payload_length = '0;
               rsp_in.ack_out        = expected_ff;
               rsp_in.send_base      = base_ff;
               rsp_in.eof_seen       = eof_ff;
               rsp_in.all_delivered  = done_in;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         expected_ff  <= SEQ_W'(1);
         exp_idx_ff   <= IDX_W'(1);
         base_ff      <= SEQ_W'(1);
         eof_ff       <= 1'b0;
         done_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         expected_ff  <= expected_in;
         exp_idx_ff   <= exp_idx_in;
         base_ff      <= base_in;
         eof_ff       <= eof_in;
         done_ff      <= done_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         seq_ff    <= req_tdata[31:0];
         ack_ff    <= req_tdata[63:32];
         hlen_ff   <= req_tdata[79:64];
         nbytes_ff <= req_tdata[95:80];
         ck_ff     <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[mem_waddr] <= pay_len;
      end
      if (byp_en) begin
         rd_len_ff <= pay_len;
      end else if (rd_en) begin
         rd_len_ff <= len_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pack_rsp(rsp_ff);
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule
